>>> hw/rtl/frb_pkg.sv
// frb_pkg: shared types and constants of the frame-rate blend pixel core.
// No dependencies; imported by every frb_* module and the top level.
`default_nettype none

package frb_pkg;

    localparam int SAMPLE_W = 8;
    localparam int PHASE_W  = 11;
    localparam int WIN_W    = 8;
    localparam int WGT_W    = 9;   // 0..256
    localparam int DIFF_W   = 9;   // signed sample, centered or not
    localparam int PROD_W   = 19;  // DIFF_W + WGT_W + sign of weight
    localparam int ACC_W    = 20;

    localparam logic [WGT_W-1:0]    FULL_WEIGHT  = 9'd256;
    localparam logic [DIFF_W-1:0]   CHROMA_MID   = 9'd128;
    localparam logic [ACC_W-1:0]    LUMA_ROUND   = 20'd128;
    localparam logic [ACC_W-1:0]    CHROMA_ROUND = 20'd32896;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX   = 8'd255;

    // configuration register indexes
    localparam logic REG_WINDOW_START = 1'b0;
    localparam logic REG_WINDOW_END   = 1'b1;

    // base_source codes
    localparam logic [1:0] SRC_PREV = 2'd0;
    localparam logic [1:0] SRC_CUR  = 2'd1;
    localparam logic [1:0] SRC_NEXT = 2'd2;

    typedef struct packed {
        logic [SAMPLE_W-1:0]       prev_sample;
        logic [SAMPLE_W-1:0]       cur_sample;
        logic [SAMPLE_W-1:0]       next_sample;
        logic signed [PHASE_W-1:0] phase;
        logic                      prev_present;
        logic                      scene_cut;
        logic                      is_chroma;
    } pix_t;

    // after phase decode
    typedef struct packed {
        logic [SAMPLE_W-1:0] base_val;
        logic [SAMPLE_W-1:0] nb_val;
        logic [WGT_W-1:0]    w_base;
        logic [WGT_W-1:0]    w_nb;
        logic                blend;
        logic                chroma;
        logic [1:0]          base;
    } sel_t;

    // after the two weight products
    typedef struct packed {
        logic signed [PROD_W-1:0] prod_base;
        logic signed [PROD_W-1:0] prod_nb;
        logic [SAMPLE_W-1:0]      base_val;
        logic                     blend;
        logic                     chroma;
        logic [1:0]               base;
    } prod_t;

endpackage

`default_nettype wire

>>> hw/rtl/frb_select.sv
// frb_select: stage 1, phase magnitude, window test, base/neighbor pick, weights.
// Depends on frb_pkg.
`default_nettype none

module frb_select (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [frb_pkg::WIN_W-1:0] window_start,
    input  wire logic [frb_pkg::WIN_W-1:0] window_end,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire frb_pkg::pix_t             in_pix,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output frb_pkg::sel_t                  out_sel
);
    import frb_pkg::*;

    logic                 valid_reg;
    sel_t                 sel_reg;
    sel_t                 sel_next;
    logic                 neg;
    logic                 pos;
    logic [PHASE_W-1:0]   mag;
    logic [PHASE_W-1:0]   ws_ext;
    logic [PHASE_W-1:0]   we_ext;
    logic                 in_win;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        neg    = in_pix.phase[PHASE_W-1];
        pos    = !neg && (in_pix.phase != '0);
        mag    = neg ? PHASE_W'(-in_pix.phase) : PHASE_W'(in_pix.phase);
        ws_ext = PHASE_W'(window_start);
        we_ext = PHASE_W'(window_end);
        in_win = (mag >= ws_ext) && (mag <= we_ext);

        sel_next.base = SRC_CUR;
        if (pos && (mag > we_ext))
            sel_next.base = SRC_NEXT;
        if (in_pix.prev_present && neg && (mag > we_ext))
            sel_next.base = SRC_PREV;

        case (sel_next.base)
            SRC_PREV: sel_next.base_val = in_pix.prev_sample;
            SRC_NEXT: sel_next.base_val = in_pix.next_sample;
            default:  sel_next.base_val = in_pix.cur_sample;
        endcase

        // neighbor on the side of the phase; zero phase leans to previous
        sel_next.nb_val = pos ? in_pix.next_sample : in_pix.prev_sample;
        sel_next.blend  = in_win && !in_pix.scene_cut && (pos || in_pix.prev_present);
        // in the window mag never exceeds 255
        sel_next.w_nb   = {1'b0, mag[WIN_W-1:0]};
        sel_next.w_base = FULL_WEIGHT - sel_next.w_nb;
        sel_next.chroma = in_pix.is_chroma;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            sel_reg <= sel_next;
    end

    assign out_valid = valid_reg;
    assign out_sel   = sel_reg;

endmodule

`default_nettype wire

>>> hw/rtl/frb_mult.sv
// frb_mult: stage 2, the two weight products (optionally centered on 128).
// Depends on frb_pkg.
`default_nettype none

module frb_mult (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire frb_pkg::sel_t in_sel,
    output logic               out_valid,
    input  wire logic          out_ready,
    output frb_pkg::prod_t     out_prod
);
    import frb_pkg::*;

    logic                     valid_reg;
    prod_t                    prod_reg;
    prod_t                    prod_next;
    logic signed [DIFF_W-1:0] d_base;
    logic signed [DIFF_W-1:0] d_nb;
    logic signed [WGT_W:0]    wb;
    logic signed [WGT_W:0]    wn;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        d_base = in_sel.chroma ? $signed({1'b0, in_sel.base_val} - CHROMA_MID)
                               : $signed({1'b0, in_sel.base_val});
        d_nb   = in_sel.chroma ? $signed({1'b0, in_sel.nb_val} - CHROMA_MID)
                               : $signed({1'b0, in_sel.nb_val});
        wb     = $signed({1'b0, in_sel.w_base});
        wn     = $signed({1'b0, in_sel.w_nb});

        // operands widened first so the product keeps all its bits
        prod_next.prod_base = PROD_W'(d_base) * PROD_W'(wb);
        prod_next.prod_nb   = PROD_W'(d_nb) * PROD_W'(wn);
        prod_next.base_val  = in_sel.base_val;
        prod_next.blend     = in_sel.blend;
        prod_next.chroma    = in_sel.chroma;
        prod_next.base      = in_sel.base;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            prod_reg <= prod_next;
    end

    assign out_valid = valid_reg;
    assign out_prod  = prod_reg;

endmodule

`default_nettype wire

>>> hw/rtl/frb_round.sv
// frb_round: stage 3, sum, rounding, clamp and the output register.
// Depends on frb_pkg.
`default_nettype none

module frb_round (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire frb_pkg::prod_t               in_prod,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [frb_pkg::SAMPLE_W-1:0]      out_sample,
    output logic                              was_blended,
    output logic [1:0]                        base_source
);
    import frb_pkg::*;

    logic                    valid_reg;
    logic [SAMPLE_W-1:0]     sample_reg;
    logic                    blended_reg;
    logic [1:0]              base_reg;
    logic signed [ACC_W-1:0] acc;
    logic [SAMPLE_W-1:0]     mixed;
    logic [SAMPLE_W-1:0]     sample_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        acc = ACC_W'(in_prod.prod_base) + ACC_W'(in_prod.prod_nb)
            + $signed(in_prod.chroma ? CHROMA_ROUND : LUMA_ROUND);
        if (acc[ACC_W-1])
            mixed = '0;
        else if (|acc[ACC_W-2:2*SAMPLE_W])
            mixed = SAMPLE_MAX;
        else
            mixed = acc[2*SAMPLE_W-1:SAMPLE_W];
        sample_next = in_prod.blend ? mixed : in_prod.base_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sample_reg  <= sample_next;
            blended_reg <= in_prod.blend;
            base_reg    <= in_prod.base;
        end
    end

    assign out_valid   = valid_reg;
    assign out_sample  = sample_reg;
    assign was_blended = blended_reg;
    assign base_source = base_reg;

endmodule

`default_nettype wire

>>> hw/rtl/frame_rate_blend_pixel.sv
// frame_rate_blend_pixel: top level of the per-pixel frame-rate blend core.
// Depends on frb_pkg, frb_select, frb_mult and frb_round.
`default_nettype none

// Per-pixel blend core. Each input beat carries co-located samples of the
// previous, current and next source frames and a signed phase (1/256 of a
// source period). Phases beyond +window_end copy the next frame, below
// -window_end the previous one (when present), otherwise the current one.
// Phase magnitudes in [window_start, window_end] mix the base with the
// neighbor on the phase side using weights 256-|phase| and |phase|, rounded,
// unless scene_cut is set or the neighbor is the previous frame and it is
// absent. Chroma mixes around 128. The datapath is three register stages
// (decode, multiply, sum/round); the last stage is the output register.
// One beat per clock while out_ready is high. Each stage holds while its
// successor is full and stalled, so a bubble anywhere lets new input in.
// Configuration (wr_en/wr_index/wr_data) takes effect on the next cycle and
// should only be written with the pipeline empty.
module frame_rate_blend_pixel (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              wr_en,
    input  wire logic                              wr_index,
    input  wire logic [frb_pkg::WIN_W-1:0]         wr_data,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [frb_pkg::SAMPLE_W-1:0]      prev_sample,
    input  wire logic [frb_pkg::SAMPLE_W-1:0]      cur_sample,
    input  wire logic [frb_pkg::SAMPLE_W-1:0]      next_sample,
    input  wire logic signed [frb_pkg::PHASE_W-1:0] phase,
    input  wire logic                              prev_present,
    input  wire logic                              scene_cut,
    input  wire logic                              is_chroma,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [frb_pkg::SAMPLE_W-1:0]           out_sample,
    output logic                                   was_blended,
    output logic [1:0]                             base_source
);
    import frb_pkg::*;

    logic [WIN_W-1:0] window_start_reg;
    logic [WIN_W-1:0] window_end_reg;

    pix_t  in_pix;
    sel_t  sel;
    prod_t prod;
    logic  s1_valid;
    logic  s1_ready;
    logic  s2_valid;
    logic  s2_ready;

    // window registers; reset values per the register map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_start_reg <= 8'd15;
            window_end_reg   <= 8'd240;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_WINDOW_START: window_start_reg <= wr_data;
                REG_WINDOW_END:   window_end_reg   <= wr_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        in_pix.prev_sample  = prev_sample;
        in_pix.cur_sample   = cur_sample;
        in_pix.next_sample  = next_sample;
        in_pix.phase        = phase;
        in_pix.prev_present = prev_present;
        in_pix.scene_cut    = scene_cut;
        in_pix.is_chroma    = is_chroma;
    end

    // stage 1: decode phase, pick sources and weights
    frb_select u_select (
        .clk          (clk),
        .rst_n        (rst_n),
        .window_start (window_start_reg),
        .window_end   (window_end_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_pix       (in_pix),
        .out_valid    (s1_valid),
        .out_ready    (s1_ready),
        .out_sel      (sel)
    );

    // stage 2: weight products
    frb_mult u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_sel    (sel),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_prod  (prod)
    );

    // stage 3: round, clamp, output register
    frb_round u_round (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s2_valid),
        .in_ready    (s2_ready),
        .in_prod     (prod),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_sample  (out_sample),
        .was_blended (was_blended),
        .base_source (base_source)
    );

    // a blend only happens inside the window, where the base is always current
    a_blend_base_cur: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_blended |-> base_source == SRC_CUR)
        else $error("blended beat with non-current base");

    // an open output drains the whole pipeline, so input must be open too
    a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while output accepts");

    // no base code beyond next
    a_base_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> base_source == SRC_PREV || base_source == SRC_CUR
                      || base_source == SRC_NEXT)
        else $error("illegal base_source code");

endmodule

`default_nettype wire

>>> tb/frame_rate_blend_pixel_tb.sv
`timescale 1ns / 100ps
// frame_rate_blend_pixel_tb: self-checking bench for the per-pixel frame-rate blend core.
// Needs frb_pkg and the frame_rate_blend_pixel RTL; a blend predictor checks every output beat.

module frame_rate_blend_pixel_tb;

    import frb_pkg::*;

    // one expected output beat
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                blended;
        logic [1:0]          src;
    } blend_out_t;

    // Blend predictor plus the queue of outputs still owed by the DUT.
    // Keeps its own copy of the two window registers.
    class blend_ledger;
        int unsigned win_start;
        int unsigned win_end;
        blend_out_t  due[$];
        int          mismatches;

        function new();
            win_start  = 15;
            win_end    = 240;
            mismatches = 0;
        endfunction

        function void track_window(int unsigned ws, int unsigned we);
            win_start = ws;
            win_end   = we;
        endfunction

        // Pick base frame by phase, then mix with the neighbor on the phase side
        // when |phase| sits inside [win_start, win_end].
        function blend_out_t blend_pixel(pix_t px);
            int                  ph;
            int                  ws;
            int                  we;
            int                  w_nb;
            int                  w_base;
            int                  acc;
            int                  s_base;
            int                  s_nb;
            logic [1:0]          src;
            logic [1:0]          nb;
            logic [SAMPLE_W-1:0] smp [3];
            blend_out_t          r;

            ph     = int'($signed(px.phase));
            ws     = int'(win_start);
            we     = int'(win_end);
            smp[0] = px.prev_sample;
            smp[1] = px.cur_sample;
            smp[2] = px.next_sample;

            src = SRC_CUR;
            if (ph > we)
                src = SRC_NEXT;
            if (px.prev_present && ph < -we)
                src = SRC_PREV;

            r.sample  = smp[src];
            r.blended = 1'b0;
            r.src     = src;

            if ((ph >= ws && ph <= we) || (ph <= -ws && ph >= -we))
            begin
                // zero phase counts as the previous-frame side
                nb = (ph > 0) ? SRC_NEXT : SRC_PREV;
                if (!px.scene_cut && (nb == SRC_NEXT || px.prev_present))
                begin
                    w_nb   = (ph < 0) ? -ph : ph;
                    w_base = int'(FULL_WEIGHT) - w_nb;
                    s_base = int'(smp[src]);
                    s_nb   = int'(smp[nb]);
                    if (px.is_chroma)
                        acc = (s_base - int'(CHROMA_MID)) * w_base
                            + (s_nb - int'(CHROMA_MID)) * w_nb + int'(CHROMA_ROUND);
                    else
                        acc = s_base * w_base + s_nb * w_nb + int'(LUMA_ROUND);
                    if (acc < 0)
                        acc = 0;
                    acc = acc >>> 8;
                    if (acc > int'(SAMPLE_MAX))
                        acc = int'(SAMPLE_MAX);
                    r.sample  = acc[SAMPLE_W-1:0];
                    r.blended = 1'b1;
                end
            end
            return r;
        endfunction

        function void note_pixel(pix_t px);
            due.push_back(blend_pixel(px));
        endfunction

        function void check_pixel(logic [SAMPLE_W-1:0] sample, logic blended,
                                  logic [1:0] src);
            blend_out_t want;

            if (due.size() == 0)
            begin
                $error("unexpected output beat: out_sample %0d was_blended %0d base_source %0d",
                       sample, blended, src);
                mismatches++;
                return;
            end
            want = due.pop_front();
            if (sample !== want.sample)
            begin
                $error("out_sample: expected %0d, got %0d", want.sample, sample);
                mismatches++;
            end
            if (blended !== want.blended)
            begin
                $error("was_blended: expected %0d, got %0d", want.blended, blended);
                mismatches++;
            end
            if (src !== want.src)
            begin
                $error("base_source: expected %0d, got %0d", want.src, src);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return due.size();
        endfunction
    endclass

    logic                       clk;
    logic                       rst_n;
    logic                       wr_en;
    logic                       wr_index;
    logic [WIN_W-1:0]           wr_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [SAMPLE_W-1:0]        prev_sample;
    logic [SAMPLE_W-1:0]        cur_sample;
    logic [SAMPLE_W-1:0]        next_sample;
    logic signed [PHASE_W-1:0]  phase;
    logic                       prev_present;
    logic                       scene_cut;
    logic                       is_chroma;
    logic                       out_valid;
    logic                       out_ready;
    logic [SAMPLE_W-1:0]        out_sample;
    logic                       was_blended;
    logic [1:0]                 base_source;

    // per-cycle idle odds, in percent, for each side
    int send_gap_pct   = 0;
    int ready_drop_pct = 0;

    blend_ledger ledger = new();

    frame_rate_blend_pixel u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .prev_sample  (prev_sample),
        .cur_sample   (cur_sample),
        .next_sample  (next_sample),
        .phase        (phase),
        .prev_present (prev_present),
        .scene_cut    (scene_cut),
        .is_chroma    (is_chroma),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_sample   (out_sample),
        .was_blended  (was_blended),
        .base_source  (base_source)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop: the ~730 beats of the run fit many times over.
    initial
    begin
        #2_000_000;
        $display("frame_rate_blend_pixel_tb failed");
        $finish;
    end

    function automatic pix_t mk_pixel(int p, int c, int n, int ph, bit pp, bit sc, bit ch);
        pix_t px;

        px.prev_sample  = p[SAMPLE_W-1:0];
        px.cur_sample   = c[SAMPLE_W-1:0];
        px.next_sample  = n[SAMPLE_W-1:0];
        px.phase        = ph[PHASE_W-1:0];
        px.prev_present = pp;
        px.scene_cut    = sc;
        px.is_chroma    = ch;
        return px;
    endfunction

    // mostly uniform, with the rails thrown in now and then
    function automatic int rand_sample();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 255;
            default: return int'($urandom_range(255));
        endcase
    endfunction

    // Phases cluster around the window bounds and the blend region,
    // with a share over the full 11-bit range.
    function automatic pix_t rand_pixel(int ws, int we);
        int ph;
        int mag;

        case ($urandom_range(9))
            0, 1:
                ph = int'($urandom_range(2047)) - 1024;
            2, 3:
            begin
                case ($urandom_range(3))
                    0:       mag = ws;
                    1:       mag = ws - 1;
                    2:       mag = we;
                    default: mag = we + 1;
                endcase
                mag = mag + int'($urandom_range(2)) - 1;
                ph  = $urandom_range(1) ? -mag : mag;
            end
            default:
                ph = int'($urandom_range(600)) - 300;
        endcase
        if (ph > 1023)
            ph = 1023;
        if (ph < -1024)
            ph = -1024;
        return mk_pixel(rand_sample(), rand_sample(), rand_sample(), ph,
                        $urandom_range(3) != 0, $urandom_range(4) == 0,
                        $urandom_range(1));
    endfunction

    // Present one input beat and hold it until accepted. Valid stays high
    // on return so back-to-back beats need no second assignment in a step.
    task automatic send_pixel(input pix_t px);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        prev_sample  <= px.prev_sample;
        cur_sample   <= px.cur_sample;
        next_sample  <= px.next_sample;
        phase        <= px.phase;
        prev_present <= px.prev_present;
        scene_cut    <= px.scene_cut;
        is_chroma    <= px.is_chroma;
        do
            @(posedge clk);
        while (!in_ready);
        ledger.note_pixel(px);
    endtask

    // Stop sending and let every owed output beat come back.
    task automatic wait_empty();
        in_valid <= 1'b0;
        while (ledger.outstanding() != 0)
            @(posedge clk);
        // three-stage pipe; keep idling to catch any stray beats
        repeat (6) @(posedge clk);
    endtask

    // Only called with the pipe empty; both registers written back to back.
    task automatic load_window(input int ws, input int we);
        wr_en    <= 1'b1;
        wr_index <= REG_WINDOW_START;
        wr_data  <= ws[WIN_W-1:0];
        @(posedge clk);
        wr_index <= REG_WINDOW_END;
        wr_data  <= we[WIN_W-1:0];
        @(posedge clk);
        wr_en    <= 1'b0;
        ledger.track_window(ws, we);
    endtask

    task automatic pick_window();
        int ws;
        int we;

        case ($urandom_range(5))
            0:
            begin
                ws = 0;
                we = 255;
            end
            1:
            begin
                ws = 15;
                we = 240;
            end
            2:
            begin
                // may well land with start above end
                ws = int'($urandom_range(255));
                we = int'($urandom_range(255));
            end
            3:
            begin
                ws = 0;
                we = 0;
            end
            4:
            begin
                ws = 255;
                we = 255;
            end
            default:
            begin
                ws = int'($urandom_range(128));
                we = int'($urandom_range(255, ws));
            end
        endcase
        load_window(ws, we);
    endtask

    // Output side: check every accepted beat, redraw ready each cycle.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                ledger.check_pixel(out_sample, was_blended, base_source);
            out_ready <= ($urandom_range(99) >= ready_drop_pct);
        end
    end

    initial
    begin
        int p;
        int b;
        int k;

        rst_n        <= 1'b0;
        wr_en        <= 1'b0;
        wr_index     <= REG_WINDOW_START;
        wr_data      <= '0;
        in_valid     <= 1'b0;
        prev_sample  <= '0;
        cur_sample   <= '0;
        next_sample  <= '0;
        phase        <= '0;
        prev_present <= 1'b0;
        scene_cut    <= 1'b0;
        is_chroma    <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset window 15..240 ---
        send_pixel(mk_pixel( 10,  20,  30,     0, 1, 0, 0)); // below window: copy current
        send_pixel(mk_pixel( 10,  20,  30,    14, 1, 0, 0));
        send_pixel(mk_pixel(  0, 255,   0,    15, 1, 0, 0)); // first blended phase
        send_pixel(mk_pixel(255,   0, 255,   -15, 1, 0, 0)); // blend toward previous
        send_pixel(mk_pixel(255,   0, 255,   240, 1, 0, 1)); // chroma at window end
        send_pixel(mk_pixel(  0, 255,   0,  -240, 1, 0, 1));
        send_pixel(mk_pixel(  1,   2,   3,   241, 1, 0, 0)); // past window: next copied
        send_pixel(mk_pixel(  1,   2,   3,  -241, 1, 0, 0)); // previous copied
        send_pixel(mk_pixel(  1,   2,   3,  -241, 0, 0, 0)); // no previous: stay on current
        send_pixel(mk_pixel(200, 100,  50,  1023, 1, 1, 1)); // phase rails
        send_pixel(mk_pixel(200, 100,  50, -1024, 1, 0, 1));
        send_pixel(mk_pixel(200, 100,  50, -1024, 0, 0, 0));
        send_pixel(mk_pixel( 90,  60,  30,   100, 1, 1, 0)); // scene cut kills the blend
        send_pixel(mk_pixel( 90,  60,  30,  -100, 0, 0, 0)); // missing neighbor kills it too
        send_pixel(mk_pixel(255, 255, 255,   128, 1, 0, 0));
        send_pixel(mk_pixel(  0,   0,   0,  -128, 1, 0, 1)); // chroma with all samples at zero
        wait_empty();

        // zero-width start: zero phase is a blend toward previous with no weight
        load_window(0, 255);
        send_pixel(mk_pixel( 40,  50,  60,     0, 1, 0, 0));
        send_pixel(mk_pixel( 40,  50,  60,     0, 0, 0, 1));
        send_pixel(mk_pixel(  0, 255, 255,   255, 1, 0, 0)); // heaviest neighbor weight
        send_pixel(mk_pixel(255,   0,   0,  -255, 1, 0, 1));
        send_pixel(mk_pixel(  7,   8,   9,   256, 1, 0, 0));
        send_pixel(mk_pixel(  7,   8,   9,  -256, 0, 0, 0));
        wait_empty();

        // start above end: nothing blends
        load_window(200, 100);
        send_pixel(mk_pixel( 10,  20,  30,   150, 1, 0, 0));
        send_pixel(mk_pixel( 10,  20,  30,  -150, 1, 0, 1));
        wait_empty();

        // --- random: three idling profiles, a few windows each ---
        for (p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    send_gap_pct   = 8;
                    ready_drop_pct = 50;
                end
                1:
                begin
                    send_gap_pct   = 50;
                    ready_drop_pct = 8;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    ready_drop_pct = 0;
                end
            endcase
            for (b = 0; b < 3; b++)
            begin
                wait_empty();
                pick_window();
                for (k = 0; k < 78; k++)
                begin
                    send_pixel(rand_pixel(int'(ledger.win_start), int'(ledger.win_end)));
                    // now and then hold off until the pipe runs dry
                    if ($urandom_range(99) == 0)
                        wait_empty();
                end
            end
        end

        wait_empty();
        if (ledger.mismatches == 0 && ledger.outstanding() == 0)
            $display("frame_rate_blend_pixel_tb passed");
        else
            $display("frame_rate_blend_pixel_tb failed");
        $finish;
    end

endmodule
